@@ design/fht_pkg.sv @@
// Shared constants, types and fixed-point helpers for the fuzzy hedge transform.
package fht_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DEG_W     = FRAC_BITS + 1;
  localparam int PROD_W    = 2 * DEG_W;

  localparam logic [DEG_W-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [DEG_W-1:0] HALF = {2'b01, {(FRAC_BITS - 1){1'b0}}};

  localparam int KIND_W    = 3;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_HEDGE_KIND = '0;

  typedef enum logic [KIND_W-1:0] {
    HEDGE_POW125,
    HEDGE_SQUARE,
    HEDGE_FOURTH,
    HEDGE_INTENSIFY,
    HEDGE_POW075,
    HEDGE_SQRT,
    HEDGE_NOT,
    HEDGE_NOT_VERY
  } hedge_t;

  typedef struct packed {
    hedge_t           kind;
    logic [DEG_W-1:0] u;
  } item_side_t;

  typedef struct packed {
    hedge_t           kind;
    logic [DEG_W-1:0] u;
    logic [DEG_W-1:0] s1;
  } root_side_t;

  typedef struct packed {
    hedge_t           kind;
    logic             low;
    logic [DEG_W-1:0] u;
    logic [DEG_W-1:0] s1;
    logic [DEG_W-1:0] p1;
  } mul1_t;

  typedef struct packed {
    hedge_t           kind;
    logic             low;
    logic [DEG_W-1:0] u;
    logic [DEG_W-1:0] s1;
    logic [DEG_W-1:0] p1;
    logic [DEG_W-1:0] p2;
  } mul2_t;

  function automatic logic [DEG_W-1:0] fx_mul(input logic [DEG_W-1:0] a,
                                               input logic [DEG_W-1:0] b);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(a) * PROD_W'(b) + PROD_W'(HALF);
    return prod[FRAC_BITS +: DEG_W];
  endfunction

endpackage

@@ design/fuzzy_hedge_transform_top.sv @@
// Top level of the fuzzy hedge transform: config register, root pipes, multiplier stages.
//
// Usage:
//   Input channel item_valid/item_ready carries one membership degree per beat on
//   degree_in (16 fraction bits, 65536 is 1.0; larger values clamp to 1.0).
//   Output channel result_valid/result_ready returns one hedged degree per beat
//   on degree_out, in input order.
//   The APB port holds hedge_kind at byte address 0; write it only while no beat
//   is in flight.
//   From accept to result_valid a beat passes the input register, which loads at the
//   accepting edge, then two square-root pipes of 17 stages each (one root bit
//   per stage), two multiplier stages and the output register.
//   Throughput is one beat per cycle while result_ready holds high; every stage has
//   its own valid bit, so a bubble anywhere is filled while the receiver stalls.
//   When result_ready is low the output register holds and stalls back stage by
//   stage; item_ready drops only once the whole pipe is full.
//   Synchronous reset clears all valid bits and sets hedge_kind to 0 (u^1.25).
module fuzzy_hedge_transform_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fht_pkg::ADDR_W-1:0]    paddr,
  input  logic [fht_pkg::DATA_W-1:0]    pwdata,
  output logic [fht_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic [fht_pkg::DEG_W-1:0]     degree_in,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [fht_pkg::DEG_W-1:0]     degree_out
);

  localparam int DEG_W  = fht_pkg::DEG_W;
  localparam int ROOT_W = fht_pkg::PROD_W;

  fht_pkg::hedge_t     hedge_kind;
  logic                cfg_write;
  logic [fht_pkg::REG_IDX_W-1:0] reg_idx;

  fht_pkg::item_side_t s0;
  logic                s0_valid;
  logic [DEG_W-1:0]    u_sat;

  logic                r1_valid, r1_ready;
  logic [DEG_W-1:0]    r1_root;
  fht_pkg::item_side_t r1_side;
  logic                r1_opnd_ready;

  fht_pkg::root_side_t r2_in_side, r2_side;
  logic                r2_valid;
  logic [DEG_W-1:0]    r2_root;

  fht_pkg::mul1_t      m1, m1_next;
  logic                m1_valid, m1_ready;
  logic [DEG_W-1:0]    mul_a, mul_b, x_int;

  fht_pkg::mul2_t      m2;
  logic                m2_valid, m2_ready;

  logic                out_ready;
  logic [DEG_W-1:0]    result_next;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[fht_pkg::ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hedge_kind <= fht_pkg::HEDGE_POW125;
    end else if (cfg_write && reg_idx == fht_pkg::REG_HEDGE_KIND) begin
      hedge_kind <= fht_pkg::hedge_t'(pwdata[fht_pkg::KIND_W-1:0]);
    end
  end

  assign prdata = (reg_idx == fht_pkg::REG_HEDGE_KIND) ?
                  fht_pkg::DATA_W'(hedge_kind) : '0;

  // Ready chain, back to front
  assign out_ready  = !result_valid || result_ready;
  assign m2_ready   = !m2_valid || out_ready;
  assign m1_ready   = !m1_valid || m2_ready;
  assign item_ready = !s0_valid || r1_opnd_ready;

  assign u_sat = (degree_in > fht_pkg::ONE) ? fht_pkg::ONE : degree_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (item_ready) begin
      s0_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s0.kind <= hedge_kind;
      s0.u    <= u_sat;
    end
  end

  fht_isqrt_pipe #(
    .W      (DEG_W),
    .SIDE_W ($bits(fht_pkg::item_side_t))
  ) u_root1 (
    .clk        (clk),
    .rst        (rst),
    .opnd_valid (s0_valid),
    .opnd_ready (r1_opnd_ready),
    .opnd       (ROOT_W'({s0.u, {fht_pkg::FRAC_BITS{1'b0}}})),
    .opnd_side  (s0),
    .root_valid (r1_valid),
    .root_ready (r1_ready),
    .root       (r1_root),
    .root_side  (r1_side)
  );

  assign r2_in_side.kind = r1_side.kind;
  assign r2_in_side.u    = r1_side.u;
  assign r2_in_side.s1   = r1_root;

  fht_isqrt_pipe #(
    .W      (DEG_W),
    .SIDE_W ($bits(fht_pkg::root_side_t))
  ) u_root2 (
    .clk        (clk),
    .rst        (rst),
    .opnd_valid (r1_valid),
    .opnd_ready (r1_ready),
    .opnd       (ROOT_W'({r1_root, {fht_pkg::FRAC_BITS{1'b0}}})),
    .opnd_side  (r2_in_side),
    .root_valid (r2_valid),
    .root_ready (m1_ready),
    .root       (r2_root),
    .root_side  (r2_side)
  );

  // First multiplier stage
  always_comb begin
    m1_next.low = r2_side.u < fht_pkg::HALF;
    x_int       = m1_next.low ? r2_side.u : fht_pkg::ONE - r2_side.u;
    mul_a       = r2_side.u;
    mul_b       = r2_side.u;
    unique case (r2_side.kind)
      fht_pkg::HEDGE_POW125: begin
        mul_a = r2_side.u;
        mul_b = r2_root;
      end
      fht_pkg::HEDGE_INTENSIFY: begin
        mul_a = x_int;
        mul_b = x_int;
      end
      fht_pkg::HEDGE_POW075: begin
        mul_a = r2_side.s1;
        mul_b = r2_root;
      end
      fht_pkg::HEDGE_SQUARE, fht_pkg::HEDGE_FOURTH, fht_pkg::HEDGE_SQRT,
      fht_pkg::HEDGE_NOT, fht_pkg::HEDGE_NOT_VERY: begin
        mul_a = r2_side.u;
        mul_b = r2_side.u;
      end
    endcase
    m1_next.kind = r2_side.kind;
    m1_next.u    = r2_side.u;
    m1_next.s1   = r2_side.s1;
    m1_next.p1   = fht_pkg::fx_mul(mul_a, mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (m1_ready) begin
      m1_valid <= r2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m1_ready && r2_valid) begin
      m1 <= m1_next;
    end
  end

  // Second multiplier stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else if (m2_ready) begin
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m2_ready && m1_valid) begin
      m2.kind <= m1.kind;
      m2.low  <= m1.low;
      m2.u    <= m1.u;
      m2.s1   <= m1.s1;
      m2.p1   <= m1.p1;
      m2.p2   <= fht_pkg::fx_mul(m1.p1, m1.p1);
    end
  end

  // Output select
  always_comb begin
    result_next = m2.p1;
    unique case (m2.kind)
      fht_pkg::HEDGE_POW125, fht_pkg::HEDGE_SQUARE, fht_pkg::HEDGE_POW075: begin
        result_next = m2.p1;
      end
      fht_pkg::HEDGE_FOURTH: begin
        result_next = m2.p2;
      end
      fht_pkg::HEDGE_INTENSIFY: begin
        result_next = m2.low ? {m2.p1[DEG_W-2:0], 1'b0}
                             : fht_pkg::ONE - {m2.p1[DEG_W-2:0], 1'b0};
      end
      fht_pkg::HEDGE_SQRT: begin
        result_next = m2.s1;
      end
      fht_pkg::HEDGE_NOT: begin
        result_next = fht_pkg::ONE - m2.u;
      end
      fht_pkg::HEDGE_NOT_VERY: begin
        result_next = fht_pkg::ONE - m2.p1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_ready) begin
      result_valid <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && m2_valid) begin
      degree_out <= result_next;
    end
  end

endmodule

@@ design/fht_isqrt_pipe.sv @@
// Pipelined integer square root, one result bit per register stage.
module fht_isqrt_pipe #(
  parameter int W      = fht_pkg::DEG_W,
  parameter int SIDE_W = fht_pkg::DEG_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              opnd_valid,
  output logic              opnd_ready,
  input  logic [2*W-1:0]    opnd,
  input  logic [SIDE_W-1:0] opnd_side,
  output logic              root_valid,
  input  logic              root_ready,
  output logic [W-1:0]      root,
  output logic [SIDE_W-1:0] root_side
);

  logic [W-1:0]      valid_q;
  logic [W:0]        stage_ready;
  logic [W+1:0]      rem_q      [W];
  logic [W-1:0]      root_q     [W];
  logic [2*W-1:0]    opnd_q     [W];
  logic [SIDE_W-1:0] side_q     [W];

  logic [W-1:0]      up_valid;
  logic [W+1:0]      rem_next   [W];
  logic [W-1:0]      root_next  [W];
  logic [2*W-1:0]    opnd_next  [W];
  logic [SIDE_W-1:0] side_next  [W];

  assign stage_ready[W] = root_ready;

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W+1:0]   up_rem;
    logic [W-1:0]   up_root;
    logic [2*W-1:0] up_opnd;
    logic [W+1:0]   rem_sh;
    logic [W+1:0]   trial;
    logic           fits;

    if (k == 0) begin : g_first
      assign up_valid[k]  = opnd_valid;
      assign up_rem       = '0;
      assign up_root      = '0;
      assign up_opnd      = opnd;
      assign side_next[k] = opnd_side;
    end else begin : g_rest
      assign up_valid[k]  = valid_q[k-1];
      assign up_rem       = rem_q[k-1];
      assign up_root      = root_q[k-1];
      assign up_opnd      = opnd_q[k-1];
      assign side_next[k] = side_q[k-1];
    end

    assign stage_ready[k] = !valid_q[k] || stage_ready[k+1];
    assign rem_sh         = {up_rem[W-1:0], up_opnd[2*W-1 -: 2]};
    assign trial          = {up_root, 2'b01};
    assign fits           = rem_sh >= trial;
    assign rem_next[k]    = fits ? rem_sh - trial : rem_sh;
    assign root_next[k]   = {up_root[W-2:0], fits};
    assign opnd_next[k]   = {up_opnd[2*W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < W; k++) begin
      if (rst) begin
        valid_q[k] <= 1'b0;
      end else if (stage_ready[k]) begin
        valid_q[k] <= up_valid[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < W; k++) begin
      if (stage_ready[k] && up_valid[k]) begin
        rem_q[k]  <= rem_next[k];
        root_q[k] <= root_next[k];
        opnd_q[k] <= opnd_next[k];
        side_q[k] <= side_next[k];
      end
    end
  end

  assign opnd_ready = stage_ready[0];
  assign root_valid = valid_q[W-1];
  assign root       = root_q[W-1];
  assign root_side  = side_q[W-1];

endmodule

@@ design/fht_checker.sv @@
// Port-level checks for the fuzzy hedge transform, bound to the top level.
module fht_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       item_ready,
  input logic                       result_valid,
  input logic                       result_ready,
  input logic [fht_pkg::DEG_W-1:0]  degree_out,
  input logic                       pready,
  input logic [fht_pkg::DATA_W-1:0] prdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(degree_out))
    else $error("result beat changed while stalled");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> degree_out <= fht_pkg::ONE)
    else $error("hedged degree above one");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && item_ready)
    else $error("pipe not empty after reset");

  a_apb_read: assert property (@(posedge clk) disable iff (rst)
    pready && prdata[fht_pkg::DATA_W-1:fht_pkg::KIND_W] == '0)
    else $error("bad register read data");

endmodule

bind fuzzy_hedge_transform_top fht_checker u_fht_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .degree_out   (degree_out),
  .pready       (pready),
  .prdata       (prdata)
);
